// ===== hw/rtl/fbacc_pkg.sv =====
// fbacc_pkg: shared types and constants of the feather blend accumulator
// used by feather_blend_accumulator and its checker; no dependencies
package fbacc_pkg;

  localparam int unsigned FramePixelsDef  = 65536;
  localparam int unsigned WeightFracDef   = 16;
  localparam int unsigned MaxStoreDepth   = 65536;

  localparam int unsigned SizeW     = 13;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned IndexW    = 16;
  localparam int unsigned ColourW   = 8;
  localparam int unsigned ColSumW   = 28;
  localparam int unsigned WtSumW    = 20;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [ColSumW-1:0] ColSumMax = '1;
  localparam logic [WtSumW-1:0]  WtSumMax  = '1;

  typedef enum logic [1:0] {
    OpClear      = 2'd0,
    OpAccumulate = 2'd1,
    OpRead       = 2'd2,
    OpNone       = 2'd3
  } opcode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgSourceWidth  = 2'd0,
    CfgSourceHeight = 2'd1,
    CfgBlendBoth    = 2'd2,
    CfgUnused       = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [ColSumW-1:0] red;
    logic [ColSumW-1:0] green;
    logic [ColSumW-1:0] blue;
    logic [WtSumW-1:0]  weight;
  } pix_sums_t;

endpackage

// ===== hw/rtl/feather_blend_accumulator.sv =====
// feather_blend_accumulator: feather-weighted pixel accumulation and readout
// over one pixel-sum memory; depends on fbacc_pkg
// clear writes zeros at once; accumulate divides for the column, then the row
// when blending both ways (F quotient bits each), then weight and colour steps
// and write; a read runs the 8-step normalizing divider lanes; out-of-store reads
// go straight to output; words are taken one at a time; read data is registered
// reset: config regs to 1024/1024/blend on, control idle, memory undefined
module feather_blend_accumulator #(
  parameter int unsigned FRAME_PIXELS         = fbacc_pkg::FramePixelsDef,
  parameter int unsigned WEIGHT_FRACTION_BITS = fbacc_pkg::WeightFracDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fbacc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [fbacc_pkg::CfgDataW-1:0]   cfg_data_i,
  // input words
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       opcode_i,
  input  logic [fbacc_pkg::IndexW-1:0]     pixel_index_i,
  input  logic [fbacc_pkg::CoordW-1:0]     source_row_i,
  input  logic [fbacc_pkg::CoordW-1:0]     source_col_i,
  input  logic                             sample_valid_i,
  input  logic [fbacc_pkg::ColourW-1:0]    red_in_i,
  input  logic [fbacc_pkg::ColourW-1:0]    green_in_i,
  input  logic [fbacc_pkg::ColourW-1:0]    blue_in_i,
  // result words
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             covered_o,
  output logic [fbacc_pkg::ColourW-1:0]    red_out_o,
  output logic [fbacc_pkg::ColourW-1:0]    green_out_o,
  output logic [fbacc_pkg::ColourW-1:0]    blue_out_o
);
  import fbacc_pkg::*;

  localparam int unsigned F      = WEIGHT_FRACTION_BITS;
  localparam int unsigned Depth  = (FRAME_PIXELS < MaxStoreDepth) ? FRAME_PIXELS
                                                                  : MaxStoreDepth;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(F);
  localparam int unsigned DenW   = SizeW + 4;
  localparam int unsigned ProdW  = F + ColourW;
  localparam int unsigned AccW   = ((ProdW > ColSumW) ? ProdW : ColSumW) + 1;
  localparam int unsigned WAccW  = ((F > WtSumW) ? F : WtSumW) + 1;
  localparam int unsigned NumW   = ColSumW + 1;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDivC  = 8'b0000_0010,
    StDivR  = 8'b0000_0100,
    StWMul  = 8'b0000_1000,
    StCMul  = 8'b0001_0000,
    StWrite = 8'b0010_0000,
    StNorm  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  // one-hot step between norm setup and iterations kept in a flag
  state_e state_q, state_d;

  // configuration registers
  logic [SizeW-1:0] width_q, height_q;
  logic             both_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(1024);
      height_q <= SizeW'(1024);
      both_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgSourceWidth:  width_q  <= cfg_data_i[SizeW-1:0];
        CfgSourceHeight: height_q <= cfg_data_i[SizeW-1:0];
        CfgBlendBoth:    both_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // accepted word
  logic               in_fire;
  logic               in_store;
  logic [AddrW-1:0]   addr_q;
  logic [CoordW-1:0]  row_q;
  logic [ColourW-1:0] r_q, g_q, b_q;

  assign in_ready_o = state_q == StIdle;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_store   = {1'b0, pixel_index_i} < (IndexW + 1)'(Depth);

  // pixel-sum memory: one read and one write port, registered read data
  pix_sums_t mem [Depth];
  pix_sums_t rd_q;
  logic      mem_we;
  pix_sums_t mem_wdata;
  logic [AddrW-1:0] mem_waddr;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= mem[pixel_index_i[AddrW-1:0]];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // shared bit-serial feather divider: t = coord * 2^F / (16 * size)
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q;
  logic [F-1:0]     quo_q;
  logic             beyond_q;
  logic [CntW-1:0]  cnt_q;
  logic [DenW:0]    div_sh;
  logic             div_ge;
  logic [F-1:0]     quo_next;
  logic [F-1:0]     term;
  logic [F-1:0]     hcol_q;
  logic [F-1:0]     w_q;
  logic [2*F-1:0]   wprod;

  assign div_sh   = {rem_q, 1'b0};
  assign div_ge   = div_sh >= {1'b0, den_q};
  assign quo_next = {quo_q[F-2:0], div_ge};
  // triangle: rising to the center, falling after, none beyond the image
  assign term     = beyond_q ? '0 : (quo_next[F-1] ? (F'(0) - quo_next) : quo_next);
  assign wprod    = (2*F)'(hcol_q) * (2*F)'(term);

  function automatic logic [DenW-1:0] size_den(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] s;
    s = (size == '0) ? SizeW'(1) : size;
    return {s, 4'b0000};
  endfunction

  // colour products and saturating sums
  logic [ProdW-1:0] pr_q, pg_q, pb_q;
  logic [AccW-1:0]  acc_r, acc_g, acc_b;
  logic [WAccW-1:0] acc_w;

  assign acc_r = AccW'(rd_q.red)   + AccW'(pr_q);
  assign acc_g = AccW'(rd_q.green) + AccW'(pg_q);
  assign acc_b = AccW'(rd_q.blue)  + AccW'(pb_q);
  assign acc_w = WAccW'(rd_q.weight) + WAccW'(w_q);

  function automatic logic [ColSumW-1:0] sat_col(input logic [AccW-1:0] v);
    return (v > AccW'(ColSumMax)) ? ColSumMax : v[ColSumW-1:0];
  endfunction

  // normalizing divider lanes: red, green, blue
  logic [2:0][WtSumW-1:0]  nrem_q;
  logic [2:0][ColourW-1:0] nlow_q;
  logic [2:0][ColourW-1:0] nquo_q;
  logic [2:0]              nsat_q;
  logic                    nsetup_q;
  logic [WtSumW-1:0]       ws_q;
  logic [2:0][ColSumW-1:0] lane_sum;
  logic [2:0][NumW-1:0]    lane_num;
  logic [2:0][WtSumW:0]    lane_sh;
  logic [2:0]              lane_ge;

  assign lane_sum = {rd_q.blue, rd_q.green, rd_q.red};

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign lane_num[l] = NumW'(lane_sum[l]) + NumW'(rd_q.weight >> 1);
    assign lane_sh[l]  = {nrem_q[l], nlow_q[l][ColourW-1]};
    assign lane_ge[l]  = lane_sh[l] >= {1'b0, ws_q};

    always_ff @(posedge clk_i) begin
      if (nsetup_q) begin
        nsat_q[l] <= lane_num[l] >= NumW'({rd_q.weight, 8'b0});
        // upper part of the numerator is below the divisor unless saturated
        nrem_q[l] <= lane_num[l][ColourW +: WtSumW];
        nlow_q[l] <= lane_num[l][ColourW-1:0];
        nquo_q[l] <= '0;
      end else if (state_q == StNorm) begin
        nrem_q[l] <= lane_ge[l] ? WtSumW'(lane_sh[l] - {1'b0, ws_q})
                                : lane_sh[l][WtSumW-1:0];
        nlow_q[l] <= {nlow_q[l][ColourW-2:0], 1'b0};
        nquo_q[l] <= {nquo_q[l][ColourW-2:0], lane_ge[l]};
      end
    end
  end

  // result staging and output register
  logic               res_cov_q;
  logic [2:0][ColourW-1:0] res_col_q;
  logic               out_valid_q;
  logic               out_load;

  assign out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      covered_o   <= res_cov_q;
      red_out_o   <= res_col_q[0];
      green_out_o <= res_col_q[1];
      blue_out_o  <= res_col_q[2];
    end
  end

  assign out_valid_o = out_valid_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (opcode_e'(opcode_i))
            OpClear: begin
              // clear writes zeros straight away
              mem_we    = in_store;
              mem_waddr = pixel_index_i[AddrW-1:0];
            end
            OpAccumulate: if (in_store && sample_valid_i) state_d = StDivC;
            OpRead:       state_d = in_store ? StNorm : StOut;
            default: ;
          endcase
        end
      end
      StDivC: begin
        if (cnt_q == '0) state_d = both_q ? StDivR : StWMul;
      end
      StDivR: begin
        if (cnt_q == '0) state_d = StWMul;
      end
      StWMul:  state_d = StCMul;
      StCMul:  state_d = StWrite;
      StWrite: begin
        mem_we    = 1'b1;
        mem_wdata.red    = sat_col(acc_r);
        mem_wdata.green  = sat_col(acc_g);
        mem_wdata.blue   = sat_col(acc_b);
        mem_wdata.weight = (acc_w > WAccW'(WtSumMax)) ? WtSumMax : acc_w[WtSumW-1:0];
        state_d = StIdle;
      end
      StNorm: begin
        // first cycle is setup; zero weight skips the iterations
        if (nsetup_q) begin
          if (rd_q.weight == '0) state_d = StOut;
        end else if (cnt_q == '0) begin
          state_d = StOut;
        end
      end
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      nsetup_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nsetup_q <= in_fire && (opcode_e'(opcode_i) == OpRead) && in_store;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          addr_q   <= pixel_index_i[AddrW-1:0];
          row_q    <= source_row_i;
          r_q      <= red_in_i;
          g_q      <= green_in_i;
          b_q      <= blue_in_i;
          den_q    <= size_den(width_q);
          beyond_q <= {1'b0, source_col_i} >= size_den(width_q);
          rem_q    <= DenW'(source_col_i);
          quo_q    <= '0;
          cnt_q    <= CntW'(F - 1);
          // out-of-store read answers uncovered
          res_cov_q <= 1'b0;
          res_col_q <= '0;
        end
      end
      StDivC, StDivR: begin
        rem_q <= div_ge ? DenW'(div_sh - {1'b0, den_q}) : div_sh[DenW-1:0];
        quo_q <= quo_next;
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          if (state_q == StDivC) begin
            hcol_q   <= term;
            w_q      <= term;
            // reload the divider for the row term
            den_q    <= size_den(height_q);
            beyond_q <= {1'b0, row_q} >= size_den(height_q);
            rem_q    <= DenW'(row_q);
            quo_q    <= '0;
            cnt_q    <= CntW'(F - 1);
          end else begin
            hcol_q <= wprod[2*F-1:F];
          end
        end
      end
      StWMul: begin
        // hcol_q already holds w in two-way mode
        if (both_q) w_q <= hcol_q;
      end
      StCMul: begin
        pr_q <= ProdW'(w_q) * ProdW'(r_q);
        pg_q <= ProdW'(w_q) * ProdW'(g_q);
        pb_q <= ProdW'(w_q) * ProdW'(b_q);
      end
      StNorm: begin
        if (nsetup_q) begin
          ws_q  <= rd_q.weight;
          cnt_q <= CntW'(ColourW - 1);
        end else begin
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            res_cov_q <= 1'b1;
            for (int l = 0; l < 3; l++) begin
              res_col_q[l] <= nsat_q[l] ? '1 : {nquo_q[l][ColourW-2:0], lane_ge[l]};
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/fbacc_checker.sv =====
// fbacc_checker: port-level assertions for feather_blend_accumulator
// depends on fbacc_pkg; bound to the top level below
module fbacc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [1:0]                      opcode_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            covered_o,
  input logic [fbacc_pkg::ColourW-1:0]   red_out_o,
  input logic [fbacc_pkg::ColourW-1:0]   green_out_o,
  input logic [fbacc_pkg::ColourW-1:0]   blue_out_o
);
  import fbacc_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(covered_o)
      && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o))
    else $error("stalled result word changed");

  // uncovered result carries zero colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !covered_o |-> red_out_o == '0 && green_out_o == '0
      && blue_out_o == '0)
    else $error("uncovered word with colour");

  // unused opcode leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OpNone |=> in_ready_o)
    else $error("unused opcode made the block busy");

  // a read keeps the block busy the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OpRead |=> !in_ready_o)
    else $error("read did not occupy the block");

endmodule

bind feather_blend_accumulator fbacc_checker u_fbacc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .covered_o   (covered_o),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o)
);

// ===== bench/tb.sv =====
// tb: self-checking bench for feather_blend_accumulator; predicts read words from
// its pixel-sum model or the directed table; depends on fbacc_pkg and the block rtl
module tb;
  import fbacc_pkg::*;

  localparam int unsigned FracBits   = WeightFracDef;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleWait = 60;  // longer than a two-way accumulate

  typedef struct packed {
    logic                covered;
    logic [ColourW-1:0]  red;
    logic [ColourW-1:0]  green;
    logic [ColourW-1:0]  blue;
  } blend_word_t;

  typedef struct {
    logic [1:0]          op;
    logic [IndexW-1:0]   pix;
    logic [CoordW-1:0]   row;
    logic [CoordW-1:0]   col;
    logic                sv;
    logic [ColourW-1:0]  r, g, b;
    bit                  typed;
    blend_word_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] opcode_i;
  logic [IndexW-1:0] pixel_index_i;
  logic [CoordW-1:0] source_row_i, source_col_i;
  logic sample_valid_i;
  logic [ColourW-1:0] red_in_i, green_in_i, blue_in_i;
  logic out_valid_o, out_ready_i, covered_o;
  logic [ColourW-1:0] red_out_o, green_out_o, blue_out_o;

  // predictor state: the bench's own copy of config and pixel sums
  logic [SizeW-1:0]   model_width, model_height;
  logic               model_both;
  logic [ColSumW-1:0] red_acc[int], green_acc[int], blue_acc[int];
  logic [WtSumW-1:0]  weight_acc[int];

  blend_word_t expected_colours[$];
  stim_row_t   stim_rows[$];
  int          pixel_pool[$];
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;

  feather_blend_accumulator u_dut (.clk_i(clk), .*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // feather term in Q.F, zero beyond the image, size 0 acts as 1
  function automatic longint unsigned feather(logic [CoordW-1:0] c, logic [SizeW-1:0] sz);
    longint unsigned one, den, t;
    one = 64'd1 << FracBits;
    den = ((sz == 0) ? 64'd1 : 64'(sz)) << 4;
    t = (64'(c) << FracBits) / den;
    if (t < (one >> 1)) return t;
    if (t < one) return one - t;
    return 0;
  endfunction

  function automatic logic [ColSumW-1:0] sat_colour(logic [ColSumW-1:0] a, longint unsigned add);
    longint unsigned s;
    s = 64'(a) + add;
    return (s > 64'(ColSumMax)) ? ColSumMax : s[ColSumW-1:0];
  endfunction

  function automatic logic [ColourW-1:0] norm_channel(logic [ColSumW-1:0] s,
                                                      logic [WtSumW-1:0] ws);
    longint unsigned q;
    q = (64'(s) + 64'(ws >> 1)) / 64'(ws);
    return (q > 255) ? 8'd255 : q[ColourW-1:0];
  endfunction

  // advance the pixel-sum model by one accepted word; returns 1 for a read
  function automatic bit predict_blend(stim_row_t w, output blend_word_t res);
    longint unsigned wt, s;
    int p;
    p = w.pix;
    res = '0;
    case (w.op)
      OpClear: begin
        red_acc[p] = '0; green_acc[p] = '0; blue_acc[p] = '0; weight_acc[p] = '0;
      end
      OpAccumulate: begin
        if (w.sv) begin
          wt = feather(w.col, model_width);
          if (model_both) wt = (wt * feather(w.row, model_height)) >> FracBits;
          red_acc[p]   = sat_colour(red_acc[p], wt * w.r);
          green_acc[p] = sat_colour(green_acc[p], wt * w.g);
          blue_acc[p]  = sat_colour(blue_acc[p], wt * w.b);
          s = 64'(weight_acc[p]) + wt;
          weight_acc[p] = (s > 64'(WtSumMax)) ? WtSumMax : s[WtSumW-1:0];
        end
      end
      OpRead: begin
        if (weight_acc[p] != 0) begin
          res.covered = 1'b1;
          res.red   = norm_channel(red_acc[p], weight_acc[p]);
          res.green = norm_channel(green_acc[p], weight_acc[p]);
          res.blue  = norm_channel(blue_acc[p], weight_acc[p]);
        end
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // receiver: random stall modes; each taken word is checked against the expected queue
  always @(posedge clk) begin
    blend_word_t got, exp_word;
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0, 3: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {covered_o, red_out_o, green_out_o, blue_out_o};
      if (expected_colours.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word %h", got);
      end else begin
        exp_word = expected_colours.pop_front();
        if (got !== exp_word) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: covered %b/%b red %0d/%0d green %0d/%0d blue %0d/%0d",
                     exp_word.covered, got.covered, exp_word.red, got.red,
                     exp_word.green, got.green, exp_word.blue, got.blue);
        end
      end
    end
  end

  // send one word; bursts of random length separated by random gaps
  task automatic send_word(stim_row_t w);
    blend_word_t res;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    opcode_i <= w.op;
    pixel_index_i <= w.pix;
    source_row_i <= w.row;
    source_col_i <= w.col;
    sample_valid_i <= w.sv;
    red_in_i <= w.r;
    green_in_i <= w.g;
    blue_in_i <= w.b;
    in_valid_i <= 1'b1;
    do @(posedge clk); while (!in_ready_o);
    burst_left--;
    if (predict_blend(w, res)) expected_colours.push_back(w.typed ? w.want : res);
  endtask

  // pause until every read word is back, then let accumulates settle
  task automatic drain;
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_colours.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgSourceWidth:  model_width = data;
      CfgSourceHeight: model_height = data;
      CfgBlendBoth:    model_both = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [CfgDataW-1:0] wd, logic [CfgDataW-1:0] ht, logic both);
    drain();
    write_reg(CfgSourceWidth, wd);
    write_reg(CfgSourceHeight, ht);
    write_reg(CfgBlendBoth, {12'd0, both});
  endtask

  task automatic add_row(logic [1:0] op, int pix, int row, int col, logic sv,
                         int r, int g, int b, bit typed, blend_word_t want);
    stim_row_t s;
    s.op = op; s.pix = IndexW'(pix); s.row = CoordW'(row); s.col = CoordW'(col);
    s.sv = sv;
    s.r = ColourW'(r); s.g = ColourW'(g); s.b = ColourW'(b);
    s.typed = typed; s.want = want;
    stim_rows.push_back(s);
  endtask

  // coordinates mostly inside the image, some just past it, a few anywhere
  function automatic logic [CoordW-1:0] pick_coord(logic [SizeW-1:0] sz);
    int unsigned span, k;
    span = ((sz == 0) ? 1 : sz) * 16;
    k = $urandom_range(0, 9);
    if (k < 7) return CoordW'($urandom_range(0, (span > 65536 ? 65536 : span) - 1));
    if (k < 9) return ((span + span / 4) > 65535) ? 16'hffff
                                                  : CoordW'($urandom_range(0, span + span / 4));
    return CoordW'($urandom);
  endfunction

  task automatic random_phase(int unsigned count);
    stim_row_t s;
    int unsigned k;
    for (int unsigned i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      s.typed = 0;
      s.want = '0;
      s.row = pick_coord(model_height);
      s.col = pick_coord(model_width);
      s.sv = ($urandom_range(0, 9) != 0);
      s.r = ColourW'($urandom); s.g = ColourW'($urandom); s.b = ColourW'($urandom);
      s.pix = IndexW'(pixel_pool[$urandom_range(0, pixel_pool.size() - 1)]);
      if (k < 58) s.op = OpAccumulate;
      else if (k < 85) s.op = OpRead;
      else if (k < 96) begin
        s.op = OpClear;
        // clears may land anywhere, which makes that pixel usable
        if ($urandom_range(0, 1) && pixel_pool.size() < 32) begin
          s.pix = IndexW'($urandom);
          pixel_pool.push_back(s.pix);
        end
      end else begin
        s.op = OpNone;
        s.pix = IndexW'($urandom);
      end
      send_word(s);
      if (i == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  initial begin
    stim_row_t s;
    blend_word_t none, hit;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0; cfg_index_i <= '0; cfg_data_i <= '0;
    in_valid_i <= 1'b0; opcode_i <= '0; pixel_index_i <= '0;
    source_row_i <= '0; source_col_i <= '0; sample_valid_i <= 1'b0;
    red_in_i <= '0; green_in_i <= '0; blue_in_i <= '0;
    model_width = 13'd1024; model_height = 13'd1024; model_both = 1'b1;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed table at reset config: center of a 1024 image is 8192 in Q12.4,
    // where the two-way weight is a quarter and a read gives the colour back
    none = '0;
    hit = {1'b1, 8'd255, 8'd0, 8'd128};
    add_row(OpClear, 0, 0, 0, 0, 0, 0, 0, 0, none);
    add_row(OpClear, 65535, 16'hffff, 16'hffff, 1, 255, 255, 255, 0, none);
    add_row(OpRead, 0, 0, 0, 0, 0, 0, 0, 1, none);
    add_row(OpRead, 65535, 0, 0, 0, 0, 0, 0, 1, none);
    // edge column gives zero weight
    add_row(OpAccumulate, 0, 8192, 0, 1, 255, 255, 255, 0, none);
    add_row(OpRead, 0, 0, 0, 0, 0, 0, 0, 1, none);
    // invalid sample is skipped
    add_row(OpAccumulate, 0, 8192, 8192, 0, 255, 255, 255, 0, none);
    add_row(OpRead, 0, 0, 0, 0, 0, 0, 0, 1, none);
    add_row(OpAccumulate, 0, 8192, 8192, 1, 255, 0, 128, 0, none);
    add_row(OpRead, 0, 0, 0, 0, 0, 0, 0, 1, hit);
    // coordinates beyond the image add nothing
    add_row(OpAccumulate, 65535, 16'hffff, 16'hffff, 1, 255, 255, 255, 0, none);
    add_row(OpRead, 65535, 0, 0, 0, 0, 0, 0, 1, none);
    // unused opcode does nothing
    add_row(OpNone, 65535, 16'hffff, 16'hffff, 1, 255, 255, 255, 0, none);
    add_row(OpRead, 0, 0, 0, 0, 0, 0, 0, 1, hit);
    add_row(OpAccumulate, 0, 4000, 12000, 1, 17, 200, 93, 0, none);
    add_row(OpAccumulate, 0, 100, 16000, 1, 1, 2, 250, 0, none);
    add_row(OpRead, 0, 0, 0, 0, 0, 0, 0, 0, none);
    add_row(OpAccumulate, 65535, 9000, 7000, 1, 0, 255, 0, 0, none);
    add_row(OpRead, 65535, 0, 0, 0, 0, 0, 0, 0, none);
    add_row(OpClear, 0, 0, 0, 0, 0, 0, 0, 0, none);
    add_row(OpRead, 0, 0, 0, 0, 0, 0, 0, 1, none);
    foreach (stim_rows[i]) send_word(stim_rows[i]);

    pixel_pool.push_back(0);
    pixel_pool.push_back(65535);
    for (int i = 0; i < 8; i++) begin
      s = '{op: OpClear, pix: IndexW'($urandom), row: 0, col: 0, sv: 0, r: 0, g: 0, b: 0,
            typed: 0, want: '0};
      pixel_pool.push_back(s.pix);
      send_word(s);
    end

    // saturation: one-way weight of one half, many bright samples on one pixel
    set_config(13'd1024, 13'd1024, 1'b0);
    for (int i = 0; i < 45; i++) begin
      s = '{op: OpAccumulate, pix: 65535, row: CoordW'($urandom), col: 8192, sv: 1,
            r: 255, g: ColourW'($urandom), b: 255, typed: 0, want: '0};
      send_word(s);
      if (i % 15 == 14) begin
        s.op = OpRead;
        send_word(s);
      end
    end

    // config sweep, extremes included; the unused index is written once
    set_config(13'd1, 13'd1, 1'b0);
    write_reg(CfgUnused, 13'h1fff);
    random_phase(110);
    set_config(13'd4096, 13'd4096, 1'b1);
    random_phase(130);
    set_config(13'd0, 13'd0, 1'b1);
    random_phase(90);
    set_config(13'd37, 13'd4095, 1'b0);
    random_phase(130);
    set_config(13'h1fff, 13'd640, 1'b1);
    random_phase(90);
    set_config(13'd1024, 13'd1024, 1'b1);
    random_phase(130);
    set_config(CfgDataW'($urandom_range(1, 4096)), CfgDataW'($urandom_range(1, 4096)),
               1'($urandom_range(0, 1)));
    random_phase(110);

    drain();
    if (fail_count == 0 && expected_colours.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
